// ----- hdl/dwpi_pkg.sv -----
// ----------------------------------------------------------------------------
// Differential-drive wheel PI package
// Shared types, register map, controller encodings and datapath widths.
// ----------------------------------------------------------------------------
package dwpi_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned OpAWidth  = 33;
  localparam int unsigned OpBWidth  = 17;
  localparam int unsigned ProdWidth = OpAWidth + OpBWidth;

  localparam logic [15:0] PropGainRst   = 16'd2560;
  localparam logic [15:0] IntGainRst    = 16'd2560;
  localparam logic [15:0] HalfBaseRst   = 16'd7537;
  localparam logic [15:0] InvRadiusRst  = 16'd7273;
  localparam logic [15:0] TicksToRadRst = 16'd11437;
  localparam logic [15:0] PeriodRst     = 16'd6554;
  localparam logic [14:0] PwmLimitRst   = 15'd32767;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
  } out_item_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] int_gain;
    logic [15:0] half_base;
    logic [15:0] inv_radius;
    logic [15:0] ticks_to_rad;
    logic [15:0] period;
    logic [14:0] pwm_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INT_GAIN     = 3'd1,
    REG_HALF_BASE    = 3'd2,
    REG_INV_RADIUS   = 3'd3,
    REG_TICKS_TO_RAD = 3'd4,
    REG_PERIOD       = 3'd5,
    REG_PWM_LIMIT    = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TURN, ST_ML, ST_MR, ST_TL, ST_TR, ST_IL,
    ST_PL, ST_IR, ST_GL, ST_PR, ST_GR, ST_LAST, ST_OUT
  } st_e;

  typedef enum logic [3:0] {
    A_ANG, A_LT, A_RT, A_DIFF, A_SUM, A_ERRL, A_ERRR, A_INTL, A_INTR
  } a_sel_e;

  typedef enum logic [2:0] {
    B_HB, B_TICKS, B_INVR, B_PERIOD, B_PROP, B_IGAIN
  } b_sel_e;

  typedef enum logic [3:0] {
    WB_NONE, WB_TURN, WB_ML, WB_MR, WB_ERRL, WB_ERRR,
    WB_INTL, WB_INTR, WB_ACC, WB_SUML, WB_SUMR
  } wb_e;

  typedef struct packed {
    logic   load_in;
    a_sel_e a_sel;
    b_sel_e b_sel;
    wb_e    wb;
    logic   load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- hdl/dwpi_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding gains, geometry, tick scale, period and the PWM limit.
// ----------------------------------------------------------------------------
module dwpi_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dwpi_pkg::AddrWidth-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  output dwpi_pkg::cfg_t                       cfg_o
);

  dwpi_pkg::cfg_t     cfg_q, cfg_d;
  dwpi_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = dwpi_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        dwpi_pkg::REG_PROP_GAIN:    cfg_d.prop_gain    = pwdata[15:0];
        dwpi_pkg::REG_INT_GAIN:     cfg_d.int_gain     = pwdata[15:0];
        dwpi_pkg::REG_HALF_BASE:    cfg_d.half_base    = pwdata[15:0];
        dwpi_pkg::REG_INV_RADIUS:   cfg_d.inv_radius   = pwdata[15:0];
        dwpi_pkg::REG_TICKS_TO_RAD: cfg_d.ticks_to_rad = pwdata[15:0];
        dwpi_pkg::REG_PERIOD:       cfg_d.period       = pwdata[15:0];
        dwpi_pkg::REG_PWM_LIMIT:    cfg_d.pwm_limit    = pwdata[14:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dwpi_pkg::REG_PROP_GAIN:    prdata = {16'd0, cfg_q.prop_gain};
      dwpi_pkg::REG_INT_GAIN:     prdata = {16'd0, cfg_q.int_gain};
      dwpi_pkg::REG_HALF_BASE:    prdata = {16'd0, cfg_q.half_base};
      dwpi_pkg::REG_INV_RADIUS:   prdata = {16'd0, cfg_q.inv_radius};
      dwpi_pkg::REG_TICKS_TO_RAD: prdata = {16'd0, cfg_q.ticks_to_rad};
      dwpi_pkg::REG_PERIOD:       prdata = {16'd0, cfg_q.period};
      dwpi_pkg::REG_PWM_LIMIT:    prdata = {17'd0, cfg_q.pwm_limit};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= dwpi_pkg::PropGainRst;
      cfg_q.int_gain     <= dwpi_pkg::IntGainRst;
      cfg_q.half_base    <= dwpi_pkg::HalfBaseRst;
      cfg_q.inv_radius   <= dwpi_pkg::InvRadiusRst;
      cfg_q.ticks_to_rad <= dwpi_pkg::TicksToRadRst;
      cfg_q.period       <= dwpi_pkg::PeriodRst;
      cfg_q.pwm_limit    <= dwpi_pkg::PwmLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hdl/dwpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// Controller
// Sequences the shared multiplier through one control tick.
// ----------------------------------------------------------------------------
module dwpi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dwpi_pkg::ctrl_sts_t   sts_i,
  output dwpi_pkg::ctrl_cmd_t   cmd_o
);

  dwpi_pkg::st_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dwpi_pkg::ST_IDLE: if (in_valid_i) state_d = dwpi_pkg::ST_TURN;
      dwpi_pkg::ST_TURN: state_d = dwpi_pkg::ST_ML;
      dwpi_pkg::ST_ML:   state_d = dwpi_pkg::ST_MR;
      dwpi_pkg::ST_MR:   state_d = dwpi_pkg::ST_TL;
      dwpi_pkg::ST_TL:   state_d = dwpi_pkg::ST_TR;
      dwpi_pkg::ST_TR:   state_d = dwpi_pkg::ST_IL;
      dwpi_pkg::ST_IL:   state_d = dwpi_pkg::ST_PL;
      dwpi_pkg::ST_PL:   state_d = dwpi_pkg::ST_IR;
      dwpi_pkg::ST_IR:   state_d = dwpi_pkg::ST_GL;
      dwpi_pkg::ST_GL:   state_d = dwpi_pkg::ST_PR;
      dwpi_pkg::ST_PR:   state_d = dwpi_pkg::ST_GR;
      dwpi_pkg::ST_GR:   state_d = dwpi_pkg::ST_LAST;
      dwpi_pkg::ST_LAST: state_d = dwpi_pkg::ST_OUT;
      dwpi_pkg::ST_OUT:  if (sts_i.out_free) state_d = dwpi_pkg::ST_IDLE;
      default:           state_d = dwpi_pkg::ST_IDLE;
    endcase
  end

  // States ST_TURN to ST_GR each issue one product; states ST_ML to ST_LAST each write back the one issued before it.
  always_comb begin
    cmd_o          = '0;
    cmd_o.a_sel    = dwpi_pkg::A_ANG;
    cmd_o.b_sel    = dwpi_pkg::B_HB;
    cmd_o.wb       = dwpi_pkg::WB_NONE;
    in_stall_o     = 1'b1;
    unique case (state_q)
      dwpi_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      dwpi_pkg::ST_TURN: begin
        cmd_o.a_sel = dwpi_pkg::A_ANG;
        cmd_o.b_sel = dwpi_pkg::B_HB;
      end
      dwpi_pkg::ST_ML: begin
        cmd_o.a_sel = dwpi_pkg::A_LT;
        cmd_o.b_sel = dwpi_pkg::B_TICKS;
        cmd_o.wb    = dwpi_pkg::WB_TURN;
      end
      dwpi_pkg::ST_MR: begin
        cmd_o.a_sel = dwpi_pkg::A_RT;
        cmd_o.b_sel = dwpi_pkg::B_TICKS;
        cmd_o.wb    = dwpi_pkg::WB_ML;
      end
      dwpi_pkg::ST_TL: begin
        cmd_o.a_sel = dwpi_pkg::A_DIFF;
        cmd_o.b_sel = dwpi_pkg::B_INVR;
        cmd_o.wb    = dwpi_pkg::WB_MR;
      end
      dwpi_pkg::ST_TR: begin
        cmd_o.a_sel = dwpi_pkg::A_SUM;
        cmd_o.b_sel = dwpi_pkg::B_INVR;
        cmd_o.wb    = dwpi_pkg::WB_ERRL;
      end
      dwpi_pkg::ST_IL: begin
        cmd_o.a_sel = dwpi_pkg::A_ERRL;
        cmd_o.b_sel = dwpi_pkg::B_PERIOD;
        cmd_o.wb    = dwpi_pkg::WB_ERRR;
      end
      dwpi_pkg::ST_PL: begin
        cmd_o.a_sel = dwpi_pkg::A_ERRL;
        cmd_o.b_sel = dwpi_pkg::B_PROP;
        cmd_o.wb    = dwpi_pkg::WB_INTL;
      end
      dwpi_pkg::ST_IR: begin
        cmd_o.a_sel = dwpi_pkg::A_ERRR;
        cmd_o.b_sel = dwpi_pkg::B_PERIOD;
        cmd_o.wb    = dwpi_pkg::WB_ACC;
      end
      dwpi_pkg::ST_GL: begin
        cmd_o.a_sel = dwpi_pkg::A_INTL;
        cmd_o.b_sel = dwpi_pkg::B_IGAIN;
        cmd_o.wb    = dwpi_pkg::WB_INTR;
      end
      dwpi_pkg::ST_PR: begin
        cmd_o.a_sel = dwpi_pkg::A_ERRR;
        cmd_o.b_sel = dwpi_pkg::B_PROP;
        cmd_o.wb    = dwpi_pkg::WB_SUML;
      end
      dwpi_pkg::ST_GR: begin
        cmd_o.a_sel = dwpi_pkg::A_INTR;
        cmd_o.b_sel = dwpi_pkg::B_IGAIN;
        cmd_o.wb    = dwpi_pkg::WB_ACC;
      end
      dwpi_pkg::ST_LAST: begin
        cmd_o.wb = dwpi_pkg::WB_SUMR;
      end
      dwpi_pkg::ST_OUT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwpi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/dwpi_dp.sv -----
// ----------------------------------------------------------------------------
// Datapath
// Shared signed multiplier, intermediate registers, integrators and output.
// ----------------------------------------------------------------------------
module dwpi_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dwpi_pkg::in_item_t    in_data_i,
  input  dwpi_pkg::cfg_t        cfg_i,
  input  dwpi_pkg::ctrl_cmd_t   cmd_i,
  output dwpi_pkg::ctrl_sts_t   sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dwpi_pkg::out_item_t   out_data_o
);

  localparam int unsigned PW = dwpi_pkg::ProdWidth;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp(input logic signed [33:0] v,
                                               input logic [14:0] lim);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    logic signed [15:0] r;
    hi = $signed({19'd0, lim});
    lo = -hi;
    if (v > hi) begin
      r = $signed({1'b0, lim});
    end else if (v < lo) begin
      r = -$signed({1'b0, lim});
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  dwpi_pkg::in_item_t  in_q;
  dwpi_pkg::out_item_t out_q;
  logic                out_valid_q;

  logic signed [PW-1:0]               p_q, p_d;
  logic signed [dwpi_pkg::OpAWidth-1:0] op_a;
  logic signed [dwpi_pkg::OpBWidth-1:0] op_b;

  logic signed [15:0] turn_q;
  logic signed [23:0] ml_q, mr_q;
  logic signed [26:0] errl_q, errr_q;
  logic signed [31:0] integl_q, integr_q;
  logic signed [43:0] acc_q;
  logic signed [33:0] suml_q, sumr_q;

  logic signed [16:0] diff, vsum;
  logic signed [25:0] target;
  logic signed [26:0] err_l, err_r;
  logic signed [27:0] inc;
  logic signed [31:0] int_l, int_r;
  logic signed [PW-1:0] total;

  assign diff = {in_q.linear_velocity[15], in_q.linear_velocity} - {turn_q[15], turn_q};
  assign vsum = {in_q.linear_velocity[15], in_q.linear_velocity} + {turn_q[15], turn_q};

  always_comb begin
    unique case (cmd_i.a_sel)
      dwpi_pkg::A_ANG:  op_a = {{17{in_q.angular_velocity[15]}}, in_q.angular_velocity};
      dwpi_pkg::A_LT:   op_a = {{17{in_q.left_ticks[15]}}, in_q.left_ticks};
      dwpi_pkg::A_RT:   op_a = {{17{in_q.right_ticks[15]}}, in_q.right_ticks};
      dwpi_pkg::A_DIFF: op_a = {{16{diff[16]}}, diff};
      dwpi_pkg::A_SUM:  op_a = {{16{vsum[16]}}, vsum};
      dwpi_pkg::A_ERRL: op_a = {{6{errl_q[26]}}, errl_q};
      dwpi_pkg::A_ERRR: op_a = {{6{errr_q[26]}}, errr_q};
      dwpi_pkg::A_INTL: op_a = {integl_q[31], integl_q};
      dwpi_pkg::A_INTR: op_a = {integr_q[31], integr_q};
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.b_sel)
      dwpi_pkg::B_HB:     op_b = {1'b0, cfg_i.half_base};
      dwpi_pkg::B_TICKS:  op_b = {1'b0, cfg_i.ticks_to_rad};
      dwpi_pkg::B_INVR:   op_b = {1'b0, cfg_i.inv_radius};
      dwpi_pkg::B_PERIOD: op_b = {1'b0, cfg_i.period};
      dwpi_pkg::B_PROP:   op_b = {1'b0, cfg_i.prop_gain};
      dwpi_pkg::B_IGAIN:  op_b = {1'b0, cfg_i.int_gain};
      default:            op_b = '0;
    endcase
  end

  assign p_d = op_a * op_b;

  // Shifted views of the product register; the floor shifts are plain selects.
  assign target = p_q[33:8];
  assign err_l  = {target[25], target} - {{3{ml_q[23]}}, ml_q};
  assign err_r  = {target[25], target} - {{3{mr_q[23]}}, mr_q};
  assign inc    = p_q[43:16];
  assign int_l  = sat32({integl_q[31], integl_q} + {{5{inc[27]}}, inc});
  assign int_r  = sat32({integr_q[31], integr_q} + {{5{inc[27]}}, inc});
  assign total  = {{(PW-44){acc_q[43]}}, acc_q} + p_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    unique case (cmd_i.wb)
      dwpi_pkg::WB_TURN: turn_q <= p_q[31:16];
      dwpi_pkg::WB_ML:   ml_q   <= p_q[31:8];
      dwpi_pkg::WB_MR:   mr_q   <= p_q[31:8];
      dwpi_pkg::WB_ERRL: errl_q <= err_l;
      dwpi_pkg::WB_ERRR: errr_q <= err_r;
      dwpi_pkg::WB_ACC:  acc_q  <= p_q[43:0];
      dwpi_pkg::WB_SUML: suml_q <= total[PW-1:16];
      dwpi_pkg::WB_SUMR: sumr_q <= total[PW-1:16];
      default: begin
      end
    endcase
    if (cmd_i.load_out) begin
      out_q.left_drive  <= clamp(suml_q, cfg_i.pwm_limit);
      out_q.right_drive <= clamp(sumr_q, cfg_i.pwm_limit);
    end
  end

  // The integrators carry state from tick to tick and are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integl_q    <= '0;
      integr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wb == dwpi_pkg::WB_INTL) begin
        integl_q <= int_l;
      end
      if (cmd_i.wb == dwpi_pkg::WB_INTR) begin
        integr_q <= int_r;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/differential_drive_wheel_pi_top.sv -----
// The single shared 33x17 multiplier performs eleven products per tick, one
// per cycle. A new request is taken as soon as the previous result is in
// the output register. Reset clears both integrators, the output valid flag
// and the controller, and loads the configuration registers with their
// defaults.
// ----------------------------------------------------------------------------
// Differential-drive wheel PI controller
// Inverse kinematics, speed measurement and a saturating PI law per wheel.
// ----------------------------------------------------------------------------
module differential_drive_wheel_pi_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dwpi_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dwpi_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dwpi_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  dwpi_pkg::cfg_t      cfg;
  dwpi_pkg::ctrl_cmd_t cmd;
  dwpi_pkg::ctrl_sts_t sts;

  dwpi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dwpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dwpi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/dwpi_checker.sv -----
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's channels and flags protocol or range slips.
// ----------------------------------------------------------------------------
module dwpi_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dwpi_pkg::out_item_t out_data_o
);

  // A result held back by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Once a request is taken the block works on it before taking another.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // The clamp is symmetric, so the most negative code never appears.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.left_drive != 16'sh8000) &&
                    (out_data_o.right_drive != 16'sh8000))
    else $error("drive outside symmetric range");

endmodule

bind differential_drive_wheel_pi_top dwpi_checker u_dwpi_checker (.*);

// ----- tb/differential_drive_wheel_pi_top_tb.sv -----
// ----------------------------------------------------------------------------
// Differential-drive wheel PI controller testbench
// Sends control-tick requests through the valid/stall input, predicts both
// wheel PWM commands with a fixed-point model kept in step with the register
// settings written over the APB port, and checks every result in order.
// ----------------------------------------------------------------------------
module differential_drive_wheel_pi_top_tb;

  localparam int unsigned ResultLatency = 14;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned NumRegs       = 7;
  localparam int unsigned PhaseItems    = 200;
  localparam logic [2:0]  RegUnused     = 3'd7;

  localparam logic signed [15:0] MaxVal = 16'sh7FFF;
  localparam logic signed [15:0] MinVal = 16'sh8000;
  localparam longint IntegMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint IntegMin = -64'sh0000_0000_8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dwpi_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dwpi_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dwpi_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Controller model state.
  dwpi_pkg::cfg_t ctrl_cfg;
  int left_accum;
  int right_accum;
  dwpi_pkg::out_item_t pending_drives[$];

  int failures = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;

  differential_drive_wheel_pi_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("differential_drive_wheel_pi_top_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off each time one is requested.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : drive_checker
    dwpi_pkg::out_item_t exp_drv;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drives.size() == 0) begin
        $error("unexpected result: left_drive %0d, right_drive %0d",
               out_data_o.left_drive, out_data_o.right_drive);
        failures++;
      end else begin
        exp_drv = pending_drives.pop_front();
        if (out_data_o.left_drive !== exp_drv.left_drive) begin
          $error("left_drive: expected %0d, got %0d", exp_drv.left_drive,
                 out_data_o.left_drive);
          failures++;
        end
        if (out_data_o.right_drive !== exp_drv.right_drive) begin
          $error("right_drive: expected %0d, got %0d", exp_drv.right_drive,
                 out_data_o.right_drive);
          failures++;
        end
      end
    end
  end

  function automatic int next_integral(input int integ, input longint err);
    longint sum;
    sum = longint'(integ) + ((err * longint'(ctrl_cfg.period)) >>> 16);
    if (sum > IntegMax) return int'(IntegMax);
    if (sum < IntegMin) return int'(IntegMin);
    return int'(sum);
  endfunction

  function automatic logic signed [15:0] pwm_command(input longint err, input int integ);
    longint pwm;
    longint lim;
    pwm = (err * longint'(ctrl_cfg.prop_gain) +
           longint'(integ) * longint'(ctrl_cfg.int_gain)) >>> 16;
    lim = longint'(ctrl_cfg.pwm_limit);
    if (pwm > lim) pwm = lim;
    if (pwm < -lim) pwm = -lim;
    return pwm[15:0];
  endfunction

  // Inverse kinematics, measured speed and the PI law; the integrals advance.
  function automatic dwpi_pkg::out_item_t predict_drives(input dwpi_pkg::in_item_t req);
    longint turn;
    longint err_l;
    longint err_r;
    dwpi_pkg::out_item_t res;
    turn = (longint'(req.angular_velocity) * longint'(ctrl_cfg.half_base)) >>> 16;
    err_l = (((longint'(req.linear_velocity) - turn) * longint'(ctrl_cfg.inv_radius)) >>> 8)
          - ((longint'(req.left_ticks) * longint'(ctrl_cfg.ticks_to_rad)) >>> 8);
    err_r = (((longint'(req.linear_velocity) + turn) * longint'(ctrl_cfg.inv_radius)) >>> 8)
          - ((longint'(req.right_ticks) * longint'(ctrl_cfg.ticks_to_rad)) >>> 8);
    left_accum = next_integral(left_accum, err_l);
    right_accum = next_integral(right_accum, err_r);
    res.left_drive = pwm_command(err_l, left_accum);
    res.right_drive = pwm_command(err_r, right_accum);
    return res;
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      dwpi_pkg::REG_PROP_GAIN:    return 32'(ctrl_cfg.prop_gain);
      dwpi_pkg::REG_INT_GAIN:     return 32'(ctrl_cfg.int_gain);
      dwpi_pkg::REG_HALF_BASE:    return 32'(ctrl_cfg.half_base);
      dwpi_pkg::REG_INV_RADIUS:   return 32'(ctrl_cfg.inv_radius);
      dwpi_pkg::REG_TICKS_TO_RAD: return 32'(ctrl_cfg.ticks_to_rad);
      dwpi_pkg::REG_PERIOD:       return 32'(ctrl_cfg.period);
      dwpi_pkg::REG_PWM_LIMIT:    return 32'(ctrl_cfg.pwm_limit);
      default:                    return 32'd0;
    endcase
  endfunction

  function automatic dwpi_pkg::in_item_t make_request(input logic signed [15:0] lin,
                                                      input logic signed [15:0] ang,
                                                      input logic signed [15:0] lt,
                                                      input logic signed [15:0] rt);
    dwpi_pkg::in_item_t req;
    req.linear_velocity = lin;
    req.angular_velocity = ang;
    req.left_ticks = lt;
    req.right_ticks = rt;
    return req;
  endfunction

  // Full-range values, with the extremes, zero and small values weighted up.
  function automatic logic signed [15:0] pick_field_value();
    case ($urandom_range(9))
      0:       return MaxVal;
      1:       return MinVal;
      2:       return 16'sd0;
      3, 4:    return 16'($urandom_range(511) - 256);
      5:       return 16'($urandom_range(8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dwpi_pkg::in_item_t random_request();
    return make_request(pick_field_value(), pick_field_value(),
                        pick_field_value(), pick_field_value());
  endfunction

  function automatic logic [15:0] pick_coeff(input logic [15:0] nominal);
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(2 * int'(nominal)));
    endcase
  endfunction

  function automatic dwpi_pkg::cfg_t random_config();
    dwpi_pkg::cfg_t c;
    c.prop_gain = pick_coeff(dwpi_pkg::PropGainRst);
    c.int_gain = pick_coeff(dwpi_pkg::IntGainRst);
    c.half_base = pick_coeff(dwpi_pkg::HalfBaseRst);
    c.inv_radius = pick_coeff(dwpi_pkg::InvRadiusRst);
    c.ticks_to_rad = pick_coeff(dwpi_pkg::TicksToRadRst);
    c.period = pick_coeff(dwpi_pkg::PeriodRst);
    case ($urandom_range(5))
      0:       c.pwm_limit = 15'd0;
      1:       c.pwm_limit = 15'h7FFF;
      default: c.pwm_limit = 15'($urandom);
    endcase
    return c;
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic send_request(input dwpi_pkg::in_item_t req);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_drives.push_back(predict_drives(req));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(2 * ResultLatency, 1)) @(posedge clk_i);
    end
  endtask

  // Always waits on the clock before it returns, so valid is never lowered and raised
  // again within one step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_drives.size() != 0);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      dwpi_pkg::REG_PROP_GAIN:    ctrl_cfg.prop_gain = value[15:0];
      dwpi_pkg::REG_INT_GAIN:     ctrl_cfg.int_gain = value[15:0];
      dwpi_pkg::REG_HALF_BASE:    ctrl_cfg.half_base = value[15:0];
      dwpi_pkg::REG_INV_RADIUS:   ctrl_cfg.inv_radius = value[15:0];
      dwpi_pkg::REG_TICKS_TO_RAD: ctrl_cfg.ticks_to_rad = value[15:0];
      dwpi_pkg::REG_PERIOD:       ctrl_cfg.period = value[15:0];
      dwpi_pkg::REG_PWM_LIMIT:    ctrl_cfg.pwm_limit = value[14:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    dwpi_pkg::reg_idx_e ridx;
    for (int i = 0; i < NumRegs; i++) begin
      ridx = dwpi_pkg::reg_idx_e'(i);
      apb_read(3'(i), rd);
      if (rd !== reg_value(3'(i))) begin
        $error("%s: expected %0d, got %0d", ridx.name(), reg_value(3'(i)), rd);
        failures++;
      end
    end
  endtask

  // Upper bits of every write carry noise that the register must drop.
  task automatic apply_config(input dwpi_pkg::cfg_t c);
    wait_drained();
    apb_write(dwpi_pkg::REG_PROP_GAIN, {16'($urandom), c.prop_gain});
    apb_write(dwpi_pkg::REG_INT_GAIN, {16'($urandom), c.int_gain});
    apb_write(dwpi_pkg::REG_HALF_BASE, {16'($urandom), c.half_base});
    apb_write(dwpi_pkg::REG_INV_RADIUS, {16'($urandom), c.inv_radius});
    apb_write(dwpi_pkg::REG_TICKS_TO_RAD, {16'($urandom), c.ticks_to_rad});
    apb_write(dwpi_pkg::REG_PERIOD, {16'($urandom), c.period});
    apb_write(dwpi_pkg::REG_PWM_LIMIT, {17'($urandom), c.pwm_limit});
    check_registers();
  endtask

  task automatic test_register_defaults();
    check_registers();
  endtask

  task automatic test_directed_extremes();
    set_idling(0, 0);
    send_request(make_request(16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_request(make_request(MaxVal, 16'sd0, 16'sd0, 16'sd0));
    send_request(make_request(MinVal, 16'sd0, 16'sd0, 16'sd0));
    send_request(make_request(16'sd0, MaxVal, 16'sd0, 16'sd0));
    send_request(make_request(16'sd0, MinVal, 16'sd0, 16'sd0));
    send_request(make_request(16'sd0, 16'sd0, MaxVal, MinVal));
    send_request(make_request(16'sd0, 16'sd0, MinVal, MaxVal));
    send_request(make_request(MaxVal, MaxVal, MaxVal, MaxVal));
    send_request(make_request(MinVal, MinVal, MinVal, MinVal));
    send_request(make_request(MaxVal, MinVal, MinVal, MinVal));
    send_request(make_request(16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555));
    send_request(make_request(16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA));
    send_request(make_request(16'sd1, -16'sd1, 16'sd1, -16'sd1));
    // A zero limit must force both commands to zero.
    wait_drained();
    apb_write(dwpi_pkg::REG_PWM_LIMIT, 32'd0);
    send_request(make_request(MaxVal, MinVal, MinVal, MaxVal));
    send_request(make_request(MinVal, MaxVal, MaxVal, MinVal));
    send_request(make_request(16'sd300, 16'sd20, -16'sd5, 16'sd7));
    wait_drained();
    apb_write(dwpi_pkg::REG_PWM_LIMIT, 32'd1);
    send_request(make_request(MaxVal, 16'sd0, MinVal, MinVal));
    send_request(make_request(MinVal, 16'sd0, MaxVal, MaxVal));
    wait_drained();
    apb_write(dwpi_pkg::REG_PWM_LIMIT, 32'hFFFF_FFFF);
    check_registers();
  endtask

  task automatic test_unknown_register();
    wait_drained();
    apb_write(RegUnused, $urandom);
    check_registers();
    repeat (3) send_request(random_request());
  endtask

  // Drive the left integral to its positive bound, then all the way to the
  // negative one; the right integral ends up pinned at its positive bound.
  // With only the integral term in play the command shows it directly.
  task automatic test_integral_saturation();
    dwpi_pkg::cfg_t c;
    c = '{prop_gain: 16'd0, int_gain: 16'd1, half_base: 16'hFFFF, inv_radius: 16'hFFFF,
          ticks_to_rad: 16'hFFFF, period: 16'hFFFF, pwm_limit: 15'h7FFF};
    apply_config(c);
    set_idling(12, 12);
    repeat (100)
      send_request(make_request(MaxVal, MinVal, MinVal + 16'($urandom_range(15)), MinVal));
    repeat (180)
      send_request(make_request(MinVal, MaxVal, MaxVal - 16'($urandom_range(15)), MinVal));
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(53, 0);
        2:       set_idling(0, 53);
        default: set_idling(12, 12);
      endcase
      apply_config(random_config());
      repeat (PhaseItems) send_request(random_request());
    end
  endtask

  task automatic test_extreme_configs();
    set_idling(12, 12);
    apply_config('0);
    repeat (30) send_request(random_request());
    apply_config('1);
    repeat (30) send_request(random_request());
  endtask

  // The receiver holds off while requests keep coming, so the block fills
  // and has to stall its input.
  task automatic test_output_holdoff();
    apply_config(random_config());
    set_idling(0, 0);
    hold_toggle <= ~hold_toggle;
    repeat (40) send_request(random_request());
  endtask

  task automatic test_drain_pause();
    set_idling(12, 12);
    for (int burst = 0; burst < 4; burst++) begin
      repeat (6) send_request(random_request());
      wait_drained();
    end
  endtask

  initial begin
    ctrl_cfg = '{prop_gain: dwpi_pkg::PropGainRst,
                 int_gain: dwpi_pkg::IntGainRst,
                 half_base: dwpi_pkg::HalfBaseRst,
                 inv_radius: dwpi_pkg::InvRadiusRst,
                 ticks_to_rad: dwpi_pkg::TicksToRadRst,
                 period: dwpi_pkg::PeriodRst,
                 pwm_limit: dwpi_pkg::PwmLimitRst};
    left_accum = 0;
    right_accum = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_directed_extremes();
    test_unknown_register();
    test_integral_saturation();
    test_random_phases();
    test_extreme_configs();
    test_output_holdoff();
    test_drain_pause();

    wait_drained();
    repeat (2 * ResultLatency) @(posedge clk_i);
    if (failures == 0) begin
      $display("differential_drive_wheel_pi_top_tb: PASS");
    end else begin
      $display("differential_drive_wheel_pi_top_tb: FAIL");
    end
    $finish;
  end

endmodule
